// ===== rtl/sta_pkg.sv =====
`default_nettype none

package sta_pkg;

    // Field formats
    localparam int VEC_W     = 24;
    localparam int FRAC_BITS = 16;
    localparam int ENT_W     = 20;
    localparam int OP_W      = 2;
    localparam int ROW_W     = 3 * ENT_W;

    // Internal widths: entry x component products, three-term sums, rounded midpoints
    localparam int PROD1_W = ENT_W + VEC_W;
    localparam int SUM1_W  = PROD1_W + 2;
    localparam int MID_W   = SUM1_W - FRAC_BITS;
    localparam int PROD2_W = ENT_W + MID_W;
    localparam int SUM2_W  = PROD2_W + 2;
    localparam int OUT_W   = SUM2_W - FRAC_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_MOTION     = 2'd0,
        OP_FORCE      = 2'd1,
        OP_INV_MOTION = 2'd2,
        OP_INV_FORCE  = 2'd3
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

    typedef logic signed [VEC_W-1:0]   t_vec;
    typedef logic signed [ENT_W-1:0]   t_ent;
    typedef logic signed [PROD1_W-1:0] t_prod1;
    typedef logic signed [SUM1_W-1:0]  t_sum1;
    typedef logic signed [MID_W-1:0]   t_mid;
    typedef logic signed [PROD2_W-1:0] t_prod2;
    typedef logic signed [SUM2_W-1:0]  t_sum2;
    typedef logic signed [OUT_W-1:0]   t_out;

    // Rounding constants, half an LSB of the result
    localparam t_sum1 HALF1 = t_sum1'(1) <<< (FRAC_BITS - 1);
    localparam t_sum2 HALF2 = t_sum2'(1) <<< (FRAC_BITS - 1);

    // Cross product index rotation: y[i] = r[NXT1]*a[NXT2] - r[NXT2]*a[NXT1]
    localparam logic [1:0] NXT1 [3] = '{2'd1, 2'd2, 2'd0};
    localparam logic [1:0] NXT2 [3] = '{2'd2, 2'd0, 2'd1};

    function automatic logic is_swap(input t_op op);
        return (op == OP_FORCE) || (op == OP_INV_FORCE);
    endfunction

    function automatic logic is_inverse(input t_op op);
        return (op == OP_INV_MOTION) || (op == OP_INV_FORCE);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sta_inner.sv =====
`default_nettype none

// First half: products against the input vector, then the rounded inner terms.
module sta_inner (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  sta_pkg::t_ctl              i_ctl,
    input  sta_pkg::t_vec              i_ang [3],
    input  sta_pkg::t_vec              i_lin [3],
    input  logic [sta_pkg::ROW_W-1:0]  i_rot [3],
    input  logic [sta_pkg::ROW_W-1:0]  i_offset,
    output sta_pkg::t_ctl              o_ctl,
    output sta_pkg::t_mid              o_x1 [3],
    output sta_pkg::t_mid              o_y [3],
    output sta_pkg::t_sum1             o_q [3],
    output sta_pkg::t_ent              o_e [3][3],
    output sta_pkg::t_ent              o_r [3]
);

    sta_pkg::t_ent   e [3][3];
    sta_pkg::t_ent   m [3][3];
    sta_pkg::t_ent   r [3];
    sta_pkg::t_vec   a [3];
    sta_pkg::t_vec   b [3];
    logic            swap;
    logic            inv;

    sta_pkg::t_prod1 n_pa [3][3];
    sta_pkg::t_prod1 n_pb [3][3];
    sta_pkg::t_prod1 n_cp [3];
    sta_pkg::t_prod1 n_cm [3];

    sta_pkg::t_ctl   r_ctl1;
    sta_pkg::t_prod1 r_pa [3][3];
    sta_pkg::t_prod1 r_pb [3][3];
    sta_pkg::t_prod1 r_cp [3];
    sta_pkg::t_prod1 r_cm [3];
    sta_pkg::t_vec   r_b1 [3];
    sta_pkg::t_ent   r_e1 [3][3];
    sta_pkg::t_ent   r_r1 [3];

    sta_pkg::t_mid   n_x1 [3];
    sta_pkg::t_mid   n_y [3];
    sta_pkg::t_sum1  n_q [3];

    sta_pkg::t_ctl   r_ctl2;
    sta_pkg::t_mid   r_x1 [3];
    sta_pkg::t_mid   r_y [3];
    sta_pkg::t_sum1  r_q [3];
    sta_pkg::t_ent   r_e2 [3][3];
    sta_pkg::t_ent   r_r2 [3];

    // Decode and stage 1 products
    always_comb begin
        swap = sta_pkg::is_swap(i_ctl.op);
        inv  = sta_pkg::is_inverse(i_ctl.op);
        for (int i = 0; i < 3; i++) begin
            r[i] = sta_pkg::t_ent'(i_offset[i*sta_pkg::ENT_W +: sta_pkg::ENT_W]);
            a[i] = swap ? i_lin[i] : i_ang[i];
            b[i] = swap ? i_ang[i] : i_lin[i];
            for (int j = 0; j < 3; j++) begin
                e[i][j] = sta_pkg::t_ent'(i_rot[i][j*sta_pkg::ENT_W +: sta_pkg::ENT_W]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i][j] = inv ? e[j][i] : e[i][j];
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_pa[i][j] = sta_pkg::t_prod1'(m[i][j]) * sta_pkg::t_prod1'(a[j]);
                n_pb[i][j] = sta_pkg::t_prod1'(m[i][j]) * sta_pkg::t_prod1'(b[j]);
            end
            n_cp[i] = sta_pkg::t_prod1'(r[sta_pkg::NXT1[i]])
                    * sta_pkg::t_prod1'(a[sta_pkg::NXT2[i]]);
            n_cm[i] = sta_pkg::t_prod1'(r[sta_pkg::NXT2[i]])
                    * sta_pkg::t_prod1'(a[sta_pkg::NXT1[i]]);
        end
    end

    // Stage 2: sums and rounding back to the vector fraction
    always_comb begin
        sta_pkg::t_sum1 s_a;
        sta_pkg::t_sum1 s_y;
        for (int i = 0; i < 3; i++) begin
            s_a = sta_pkg::t_sum1'(r_pa[i][0]) + sta_pkg::t_sum1'(r_pa[i][1])
                + sta_pkg::t_sum1'(r_pa[i][2]) + sta_pkg::HALF1;
            s_y = (sta_pkg::t_sum1'(r_b1[i]) <<< sta_pkg::FRAC_BITS)
                - sta_pkg::t_sum1'(r_cp[i]) + sta_pkg::t_sum1'(r_cm[i]) + sta_pkg::HALF1;
            n_x1[i] = s_a[sta_pkg::SUM1_W-1:sta_pkg::FRAC_BITS];
            n_y[i]  = s_y[sta_pkg::SUM1_W-1:sta_pkg::FRAC_BITS];
            n_q[i]  = sta_pkg::t_sum1'(r_pb[i][0]) + sta_pkg::t_sum1'(r_pb[i][1])
                    + sta_pkg::t_sum1'(r_pb[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_cp <= n_cp;
            r_cm <= n_cm;
            r_b1 <= b;
            r_e1 <= e;
            r_r1 <= r;
            r_x1 <= n_x1;
            r_y  <= n_y;
            r_q  <= n_q;
            r_e2 <= r_e1;
            r_r2 <= r_r1;
        end
    end

    assign o_ctl = r_ctl2;
    assign o_x1  = r_x1;
    assign o_y   = r_y;
    assign o_q   = r_q;
    assign o_e   = r_e2;
    assign o_r   = r_r2;

endmodule

`default_nettype wire

// ===== rtl/sta_outer.sv =====
`default_nettype none

// Second half: outer rotation (forward ops) or offset cross term (inverse ops)
// on a shared bank of nine multipliers, then the final sum and rounding.
module sta_outer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  sta_pkg::t_ctl  i_ctl,
    input  sta_pkg::t_mid  i_x1 [3],
    input  sta_pkg::t_mid  i_y [3],
    input  sta_pkg::t_sum1 i_q [3],
    input  sta_pkg::t_ent  i_e [3][3],
    input  sta_pkg::t_ent  i_r [3],
    output sta_pkg::t_ctl  o_ctl,
    output sta_pkg::t_mid  o_x1 [3],
    output sta_pkg::t_out  o_f [3]
);

    sta_pkg::t_ent   ma [3][3];
    sta_pkg::t_mid   mb [3][3];
    sta_pkg::t_prod2 n_p2 [3][3];
    logic            inv3;
    logic            inv4;

    sta_pkg::t_ctl   r_ctl3;
    sta_pkg::t_prod2 r_p2 [3][3];
    sta_pkg::t_sum1  r_q3 [3];
    sta_pkg::t_mid   r_x13 [3];

    sta_pkg::t_out   n_f [3];

    sta_pkg::t_ctl   r_ctl4;
    sta_pkg::t_mid   r_x14 [3];
    sta_pkg::t_out   r_f [3];

    always_comb begin
        inv3 = sta_pkg::is_inverse(i_ctl.op);
        for (int i = 0; i < 3; i++) begin
            if (inv3) begin
                ma[i][0] = i_r[sta_pkg::NXT1[i]];
                mb[i][0] = i_x1[sta_pkg::NXT2[i]];
                ma[i][1] = i_r[sta_pkg::NXT2[i]];
                mb[i][1] = i_x1[sta_pkg::NXT1[i]];
                ma[i][2] = '0;
                mb[i][2] = '0;
            end else begin
                for (int j = 0; j < 3; j++) begin
                    ma[i][j] = i_e[i][j];
                    mb[i][j] = i_y[j];
                end
            end
            for (int j = 0; j < 3; j++) begin
                n_p2[i][j] = sta_pkg::t_prod2'(ma[i][j]) * sta_pkg::t_prod2'(mb[i][j]);
            end
        end
    end

    always_comb begin
        sta_pkg::t_sum2 s;
        inv4 = sta_pkg::is_inverse(r_ctl3.op);
        for (int i = 0; i < 3; i++) begin
            if (inv4) begin
                s = sta_pkg::t_sum2'(r_q3[i]) + sta_pkg::t_sum2'(r_p2[i][0])
                  - sta_pkg::t_sum2'(r_p2[i][1]) + sta_pkg::HALF2;
            end else begin
                s = sta_pkg::t_sum2'(r_p2[i][0]) + sta_pkg::t_sum2'(r_p2[i][1])
                  + sta_pkg::t_sum2'(r_p2[i][2]) + sta_pkg::HALF2;
            end
            n_f[i] = s[sta_pkg::SUM2_W-1:sta_pkg::FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else if (i_en) begin
            r_ctl3 <= i_ctl;
            r_ctl4 <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2  <= n_p2;
            r_q3  <= i_q;
            r_x13 <= i_x1;
            r_x14 <= r_x13;
            r_f   <= n_f;
        end
    end

    assign o_ctl = r_ctl4;
    assign o_x1  = r_x14;
    assign o_f   = r_f;

endmodule

`default_nettype wire

// ===== rtl/sta_clip.sv =====
`default_nettype none

// Saturation to the vector range, angular/linear ordering, output register.
module sta_clip (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  sta_pkg::t_ctl i_ctl,
    input  sta_pkg::t_mid i_x1 [3],
    input  sta_pkg::t_out i_f [3],
    output logic          o_valid,
    output sta_pkg::t_vec o_ang [3],
    output sta_pkg::t_vec o_lin [3],
    output logic          o_sat
);

    localparam sta_pkg::t_vec VMAX = {1'b0, {(sta_pkg::VEC_W-1){1'b1}}};
    localparam sta_pkg::t_vec VMIN = {1'b1, {(sta_pkg::VEC_W-1){1'b0}}};

    sta_pkg::t_vec n_ang [3];
    sta_pkg::t_vec n_lin [3];
    logic          n_sat;

    logic          r_valid;
    sta_pkg::t_vec r_ang [3];
    sta_pkg::t_vec r_lin [3];
    logic          r_sat;

    always_comb begin
        sta_pkg::t_out xa;
        sta_pkg::t_out xb;
        sta_pkg::t_vec ca;
        sta_pkg::t_vec cb;
        logic          fa;
        logic          fb;
        logic          swap;
        swap  = sta_pkg::is_swap(i_ctl.op);
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            xa = sta_pkg::t_out'(i_x1[i]);
            xb = i_f[i];
            // fits when all bits from the top down to the sign position agree
            fa = (&xa[sta_pkg::OUT_W-1:sta_pkg::VEC_W-1]) |
                 ~(|xa[sta_pkg::OUT_W-1:sta_pkg::VEC_W-1]);
            fb = (&xb[sta_pkg::OUT_W-1:sta_pkg::VEC_W-1]) |
                 ~(|xb[sta_pkg::OUT_W-1:sta_pkg::VEC_W-1]);
            ca = fa ? xa[sta_pkg::VEC_W-1:0] : (xa[sta_pkg::OUT_W-1] ? VMIN : VMAX);
            cb = fb ? xb[sta_pkg::VEC_W-1:0] : (xb[sta_pkg::OUT_W-1] ? VMIN : VMAX);
            n_sat    = n_sat | ~fa | ~fb;
            n_ang[i] = swap ? cb : ca;
            n_lin[i] = swap ? ca : cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
            r_lin <= n_lin;
            r_sat <= n_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_ang   = r_ang;
    assign o_lin   = r_lin;
    assign o_sat   = r_sat;

endmodule

`default_nettype wire

// ===== rtl/spatial_transform_apply.sv =====
// Five register stages, the output register last, take the input transaction to its result.
// Throughput: one transaction per cycle unless the output stalls; twenty-four
// 20x24 multipliers feed the inner terms and a shared bank of nine 20x30 multipliers
// the outer terms. Output stall freezes every stage together; nothing is dropped
// or repeated. Reset (synchronous, active low) clears all stage valid bits; no data
// state.
`default_nettype none

module spatial_transform_apply (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [sta_pkg::OP_W-1:0]   i_operation,
    input  logic signed [sta_pkg::VEC_W-1:0] i_ang_x,
    input  logic signed [sta_pkg::VEC_W-1:0] i_ang_y,
    input  logic signed [sta_pkg::VEC_W-1:0] i_ang_z,
    input  logic signed [sta_pkg::VEC_W-1:0] i_lin_x,
    input  logic signed [sta_pkg::VEC_W-1:0] i_lin_y,
    input  logic signed [sta_pkg::VEC_W-1:0] i_lin_z,
    input  logic [sta_pkg::ROW_W-1:0]  i_rot_row0,
    input  logic [sta_pkg::ROW_W-1:0]  i_rot_row1,
    input  logic [sta_pkg::ROW_W-1:0]  i_rot_row2,
    input  logic [sta_pkg::ROW_W-1:0]  i_offset_xyz,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [sta_pkg::VEC_W-1:0] o_out_ang_x,
    output logic signed [sta_pkg::VEC_W-1:0] o_out_ang_y,
    output logic signed [sta_pkg::VEC_W-1:0] o_out_ang_z,
    output logic signed [sta_pkg::VEC_W-1:0] o_out_lin_x,
    output logic signed [sta_pkg::VEC_W-1:0] o_out_lin_y,
    output logic signed [sta_pkg::VEC_W-1:0] o_out_lin_z,
    output logic                       o_saturated
);

    logic                      en;
    sta_pkg::t_ctl             in_ctl;
    sta_pkg::t_vec             w_ang [3];
    sta_pkg::t_vec             w_lin [3];
    logic [sta_pkg::ROW_W-1:0] w_rot [3];

    sta_pkg::t_ctl             mid_ctl;
    sta_pkg::t_mid             mid_x1 [3];
    sta_pkg::t_mid             mid_y [3];
    sta_pkg::t_sum1            mid_q [3];
    sta_pkg::t_ent             mid_e [3][3];
    sta_pkg::t_ent             mid_r [3];

    sta_pkg::t_ctl             fin_ctl;
    sta_pkg::t_mid             fin_x1 [3];
    sta_pkg::t_out             fin_f [3];

    sta_pkg::t_vec             res_ang [3];
    sta_pkg::t_vec             res_lin [3];

    // whole pipeline advances unless a finished result is held
    assign en         = ~o_out_valid | i_out_ready;
    assign o_in_ready = en;

    assign in_ctl.valid = i_in_valid;
    assign in_ctl.op    = sta_pkg::t_op'(i_operation);

    assign w_ang[0] = i_ang_x;
    assign w_ang[1] = i_ang_y;
    assign w_ang[2] = i_ang_z;
    assign w_lin[0] = i_lin_x;
    assign w_lin[1] = i_lin_y;
    assign w_lin[2] = i_lin_z;
    assign w_rot[0] = i_rot_row0;
    assign w_rot[1] = i_rot_row1;
    assign w_rot[2] = i_rot_row2;

    sta_inner u_inner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (in_ctl),
        .i_ang    (w_ang),
        .i_lin    (w_lin),
        .i_rot    (w_rot),
        .i_offset (i_offset_xyz),
        .o_ctl    (mid_ctl),
        .o_x1     (mid_x1),
        .o_y      (mid_y),
        .o_q      (mid_q),
        .o_e      (mid_e),
        .o_r      (mid_r)
    );

    sta_outer u_outer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (mid_ctl),
        .i_x1    (mid_x1),
        .i_y     (mid_y),
        .i_q     (mid_q),
        .i_e     (mid_e),
        .i_r     (mid_r),
        .o_ctl   (fin_ctl),
        .o_x1    (fin_x1),
        .o_f     (fin_f)
    );

    sta_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (fin_ctl),
        .i_x1    (fin_x1),
        .i_f     (fin_f),
        .o_valid (o_out_valid),
        .o_ang   (res_ang),
        .o_lin   (res_lin),
        .o_sat   (o_saturated)
    );

    assign o_out_ang_x = res_ang[0];
    assign o_out_ang_y = res_ang[1];
    assign o_out_ang_z = res_ang[2];
    assign o_out_lin_x = res_lin[0];
    assign o_out_lin_y = res_lin[1];
    assign o_out_lin_z = res_lin[2];

endmodule

`default_nettype wire
